// ===== src/str_unesc_pkg.sv =====
// Shared types and constants for the string literal unescape block.
// No dependencies; used by the core and its checker.
`default_nettype none

package str_unesc_pkg;

  localparam int COUNT_WIDTH = 12;
  localparam int CAP_WIDTH   = 12;
  localparam int OCT_WIDTH   = 6;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH;

  localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(255);

  // Result queue between the decoder and the output port
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_WIDTH  = $clog2(FIFO_DEPTH);
  localparam int FILL_WIDTH = $clog2(FIFO_DEPTH + 1);

  // Source bytes
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_DIGIT_0   = 8'h30;
  localparam logic [7:0] CH_DIGIT_7   = 8'h37;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_B   = 8'h62;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_LOWER_V   = 8'h76;

  // Decoded escape values
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_VT = 8'h0B;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NEWLINE   = 2'd1,
    STATUS_TOO_LONG  = 2'd2,
    STATUS_NO_STRING = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       last;
    status_t    status;
  } result_t;

endpackage

`default_nettype wire

// ===== src/string_literal_unescape_core.sv =====
// Top level of the string literal unescape block: byte decoder and result queue.
// Depends on str_unesc_pkg for constants and the result word type.
//
// Usage:
//   Input channel (in_valid / in_stall / byte_in) takes one source byte per
//   word; end of file is fed as a newline byte. Output channel (out_valid /
//   out_stall / char_out, char_valid, last, status) delivers result words:
//   decoded characters, end markers with a status, and no-string results.
//   The mode machine decodes a byte in the cycle it is accepted and writes its
//   zero, one or two results into a four-entry result queue; each result is
//   registered there before it reaches the output.
//   Throughput is one byte per cycle while in_stall is low.
//   A byte that ends an octal escape can give two results; output drains
//   one result per cycle unless stalled; the queue absorbs the extra word.
//   in_stall rises when the queue holds more than two words, i.e. only when
//   the receiver stalls long enough to back the queue up; a stalled result
//   holds its value.
//   cfg_wr_en / cfg_wr_data write capacity (reset 255); write it only
//   while idle.
//   Reset (rst, synchronous) empties the queue and returns to idle.
`default_nettype none

module string_literal_unescape_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [str_unesc_pkg::CAP_WIDTH-1:0] cfg_wr_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [7:0]                          byte_in,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [7:0]                               char_out,
  output logic                                     char_valid,
  output logic                                     last,
  output logic [1:0]                               status
);

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_OCT1 = 3'd3,
    MODE_OCT2 = 3'd4,
    MODE_SKIP = 3'd5
  } mode_t;

  typedef logic [str_unesc_pkg::COUNT_WIDTH-1:0] count_t;
  typedef logic [str_unesc_pkg::CAP_WIDTH-1:0]   cap_t;

  mode_t                                 mode, mode_next;
  logic [str_unesc_pkg::OCT_WIDTH-1:0]   octal_value, octal_value_next;
  count_t                                char_count, char_count_next;
  str_unesc_pkg::status_t                error_kind, error_kind_next;
  cap_t                                  capacity;

  str_unesc_pkg::result_t                res [2];
  logic [1:0]                            res_count;

  str_unesc_pkg::result_t                entries [str_unesc_pkg::FIFO_DEPTH];
  logic [str_unesc_pkg::PTR_WIDTH-1:0]   wr_ptr, rd_ptr, wr_ptr_plus1;
  logic [str_unesc_pkg::FILL_WIDTH-1:0]  fill;
  logic                                  accept, pop;

  function automatic logic is_full(input count_t c, input cap_t cap);
    return (str_unesc_pkg::CMP_WIDTH'(c) >= str_unesc_pkg::CMP_WIDTH'(cap)) ||
           (c == {str_unesc_pkg::COUNT_WIDTH{1'b1}});
  endfunction

  function automatic str_unesc_pkg::result_t char_word(input logic [7:0] ch);
    str_unesc_pkg::result_t r;
    r.char_out   = ch;
    r.char_valid = 1'b1;
    r.last       = 1'b0;
    r.status     = str_unesc_pkg::STATUS_OK;
    return r;
  endfunction

  function automatic str_unesc_pkg::result_t end_word(input str_unesc_pkg::status_t st);
    str_unesc_pkg::result_t r;
    r.char_out   = 8'h00;
    r.char_valid = 1'b0;
    r.last       = 1'b1;
    r.status     = st;
    return r;
  endfunction

  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;
  assign in_stall = fill > str_unesc_pkg::FILL_WIDTH'(2);

  // Decode one byte: an optional character store, then an optional body pass
  always_comb begin
    logic       do_store, do_body, is_digit;
    logic [7:0] store_ch;
    do_store         = 1'b0;
    do_body          = 1'b0;
    store_ch         = byte_in;
    is_digit         = byte_in inside {[str_unesc_pkg::CH_DIGIT_0:str_unesc_pkg::CH_DIGIT_7]};
    mode_next        = mode;
    octal_value_next = octal_value;
    char_count_next  = char_count;
    error_kind_next  = error_kind;
    res_count        = 2'd0;
    res[0]           = '0;
    res[1]           = '0;

    case (mode)
      MODE_IDLE: begin
        if (byte_in == str_unesc_pkg::CH_QUOTE) begin
          mode_next        = MODE_STR;
          char_count_next  = '0;
          error_kind_next  = str_unesc_pkg::STATUS_OK;
          octal_value_next = '0;
        end else begin
          res[0]    = end_word(str_unesc_pkg::STATUS_NO_STRING);
          res_count = 2'd1;
        end
      end
      MODE_STR, MODE_SKIP: begin
        do_body = 1'b1;
      end
      MODE_ESC: begin
        mode_next = MODE_STR;
        if (is_digit) begin
          octal_value_next = {{(str_unesc_pkg::OCT_WIDTH-3){1'b0}}, byte_in[2:0]};
          mode_next        = MODE_OCT1;
        end else begin
          do_store = 1'b1;
          case (byte_in)
            str_unesc_pkg::CH_LOWER_R: store_ch = str_unesc_pkg::CH_CR;
            str_unesc_pkg::CH_LOWER_N: store_ch = str_unesc_pkg::CH_LF;
            str_unesc_pkg::CH_LOWER_B: store_ch = str_unesc_pkg::CH_BS;
            str_unesc_pkg::CH_LOWER_T: store_ch = str_unesc_pkg::CH_HT;
            str_unesc_pkg::CH_LOWER_F: store_ch = str_unesc_pkg::CH_FF;
            str_unesc_pkg::CH_LOWER_V: store_ch = str_unesc_pkg::CH_VT;
            default:                   store_ch = byte_in;
          endcase
        end
      end
      MODE_OCT1: begin
        if (is_digit) begin
          octal_value_next = {octal_value[2:0], byte_in[2:0]};
          mode_next        = MODE_OCT2;
        end else begin
          mode_next = MODE_STR;
          do_store  = 1'b1;
          store_ch  = {2'b00, octal_value};
          do_body   = 1'b1;
        end
      end
      MODE_OCT2: begin
        mode_next = MODE_STR;
        do_store  = 1'b1;
        if (is_digit) begin
          store_ch = {octal_value[4:0], byte_in[2:0]};
        end else begin
          store_ch = {2'b00, octal_value};
          do_body  = 1'b1;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase

    if (do_store) begin
      if (is_full(char_count_next, capacity)) begin
        error_kind_next = str_unesc_pkg::STATUS_TOO_LONG;
        mode_next       = MODE_SKIP;
      end else begin
        res[0]          = char_word(store_ch);
        res_count       = 2'd1;
        char_count_next = char_count_next + count_t'(1);
      end
    end

    if (do_body) begin
      if (byte_in == str_unesc_pkg::CH_QUOTE) begin
        res[res_count[0]] = end_word(error_kind_next);
        res_count         = res_count + 2'd1;
        mode_next         = MODE_IDLE;
      end else if (mode_next != MODE_SKIP) begin
        if (byte_in == str_unesc_pkg::CH_NEWLINE) begin
          error_kind_next = str_unesc_pkg::STATUS_NEWLINE;
          mode_next       = MODE_SKIP;
        end else if (byte_in == str_unesc_pkg::CH_BACKSLASH) begin
          mode_next = MODE_ESC;
        end else if (is_full(char_count_next, capacity)) begin
          error_kind_next = str_unesc_pkg::STATUS_TOO_LONG;
          mode_next       = MODE_SKIP;
        end else begin
          res[res_count[0]] = char_word(byte_in);
          res_count         = res_count + 2'd1;
          char_count_next   = char_count_next + count_t'(1);
        end
      end
    end
  end

  assign wr_ptr_plus1 = wr_ptr + str_unesc_pkg::PTR_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      octal_value <= '0;
      char_count  <= '0;
      error_kind  <= str_unesc_pkg::STATUS_OK;
      capacity    <= str_unesc_pkg::CAP_RESET;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      fill        <= '0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (accept) begin
        mode        <= mode_next;
        octal_value <= octal_value_next;
        char_count  <= char_count_next;
        error_kind  <= error_kind_next;
        wr_ptr      <= wr_ptr + str_unesc_pkg::PTR_WIDTH'(res_count);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + str_unesc_pkg::PTR_WIDTH'(1);
      end
      fill <= fill + (accept ? str_unesc_pkg::FILL_WIDTH'(res_count) : '0)
                   - str_unesc_pkg::FILL_WIDTH'(pop);
    end
  end

  // Result words; no reset needed on payload
  always_ff @(posedge clk) begin
    if (accept && res_count != 2'd0) begin
      entries[wr_ptr] <= res[0];
    end
    if (accept && res_count == 2'd2) begin
      entries[wr_ptr_plus1] <= res[1];
    end
  end

  assign out_valid  = fill != '0;
  assign char_out   = entries[rd_ptr].char_out;
  assign char_valid = entries[rd_ptr].char_valid;
  assign last       = entries[rd_ptr].last;
  assign status     = entries[rd_ptr].status;

endmodule

`default_nettype wire

// ===== src/str_unesc_checker.sv =====
// Port-level checks for string_literal_unescape_core, attached by bind.
// Depends on str_unesc_pkg for status codes.
`default_nettype none

module str_unesc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] char_out,
  input wire logic       char_valid,
  input wire logic       last,
  input wire logic [1:0] status
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(char_out) && $stable(char_valid)
                               && $stable(last) && $stable(status))
    else $error("stalled result word changed");

  // An empty queue never backs up the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result pending");

  a_char_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_valid |-> !last && status == str_unesc_pkg::STATUS_OK)
    else $error("character word carries end flag or status");

  a_end_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> last && char_out == 8'h00)
    else $error("end word malformed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind string_literal_unescape_core str_unesc_checker u_str_unesc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .char_out   (char_out),
  .char_valid (char_valid),
  .last       (last),
  .status     (status)
);

`default_nettype wire

// ===== tb/string_literal_unescape_checker.sv =====
`timescale 1ns / 1ps
// Checker for the string literal unescape core: decodes every accepted byte
// in its own mode machine and compares each result word with the oldest one due.
// Depends on str_unesc_pkg for the result word type and byte constants.

module string_literal_unescape_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [str_unesc_pkg::CAP_WIDTH-1:0] cfg_wr_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [7:0]                          byte_in,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [7:0]                          char_out,
  input  logic                                char_valid,
  input  logic                                last,
  input  logic [1:0]                          status,
  output int unsigned                         mismatch_count,
  output int unsigned                         words_due,
  output logic                                decoder_idle
);

  typedef enum logic [2:0] {
    DEC_IDLE,
    DEC_BODY,
    DEC_ESCAPE,
    DEC_OCTAL1,
    DEC_OCTAL2,
    DEC_DROP
  } dec_mode_t;

  localparam logic [str_unesc_pkg::COUNT_WIDTH-1:0] COUNT_FULL = '1;

  dec_mode_t                               dec_mode;
  logic [str_unesc_pkg::OCT_WIDTH-1:0]     octal_acc;
  logic [str_unesc_pkg::COUNT_WIDTH-1:0]   char_count;
  str_unesc_pkg::status_t                  err_kind;
  logic [str_unesc_pkg::CAP_WIDTH-1:0]     capacity;
  str_unesc_pkg::result_t                  due_words[$];

  assign words_due    = due_words.size();
  assign decoder_idle = (dec_mode == DEC_IDLE);

  function automatic str_unesc_pkg::result_t make_word(logic [7:0] ch, logic valid,
                                                       logic lst,
                                                       str_unesc_pkg::status_t st);
    str_unesc_pkg::result_t w;
    w.char_out   = ch;
    w.char_valid = valid;
    w.last       = lst;
    w.status     = st;
    return w;
  endfunction

  function automatic logic is_octal(logic [7:0] b);
    return (b >= str_unesc_pkg::CH_DIGIT_0) && (b <= str_unesc_pkg::CH_DIGIT_7);
  endfunction

  function automatic logic [7:0] escape_value(logic [7:0] b);
    case (b)
      str_unesc_pkg::CH_LOWER_R: return str_unesc_pkg::CH_CR;
      str_unesc_pkg::CH_LOWER_N: return str_unesc_pkg::CH_LF;
      str_unesc_pkg::CH_LOWER_B: return str_unesc_pkg::CH_BS;
      str_unesc_pkg::CH_LOWER_T: return str_unesc_pkg::CH_HT;
      str_unesc_pkg::CH_LOWER_F: return str_unesc_pkg::CH_FF;
      str_unesc_pkg::CH_LOWER_V: return str_unesc_pkg::CH_VT;
      default:                   return b;
    endcase
  endfunction

  // Emit a decoded character, or flag too-long and start dropping.
  task automatic store_char(input logic [7:0] c);
    if (char_count >= capacity || char_count == COUNT_FULL) begin
      err_kind = str_unesc_pkg::STATUS_TOO_LONG;
      dec_mode = DEC_DROP;
    end else begin
      due_words.push_back(make_word(c, 1'b1, 1'b0, str_unesc_pkg::STATUS_OK));
      char_count = char_count + 1'b1;
    end
  endtask

  task automatic body_byte(input logic [7:0] b);
    if (b == str_unesc_pkg::CH_QUOTE) begin
      due_words.push_back(make_word(8'h00, 1'b0, 1'b1, err_kind));
      dec_mode = DEC_IDLE;
    end else if (dec_mode != DEC_DROP) begin
      if (b == str_unesc_pkg::CH_NEWLINE) begin
        err_kind = str_unesc_pkg::STATUS_NEWLINE;
        dec_mode = DEC_DROP;
      end else if (b == str_unesc_pkg::CH_BACKSLASH) begin
        dec_mode = DEC_ESCAPE;
      end else begin
        store_char(b);
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    case (dec_mode)
      DEC_IDLE: begin
        if (b == str_unesc_pkg::CH_QUOTE) begin
          dec_mode   = DEC_BODY;
          char_count = '0;
          err_kind   = str_unesc_pkg::STATUS_OK;
          octal_acc  = '0;
        end else begin
          due_words.push_back(make_word(8'h00, 1'b0, 1'b1,
                                        str_unesc_pkg::STATUS_NO_STRING));
        end
      end
      DEC_BODY, DEC_DROP: body_byte(b);
      DEC_ESCAPE: begin
        dec_mode = DEC_BODY;
        if (is_octal(b)) begin
          octal_acc = {3'b000, b[2:0]};
          dec_mode  = DEC_OCTAL1;
        end else begin
          store_char(escape_value(b));
        end
      end
      DEC_OCTAL1: begin
        if (is_octal(b)) begin
          octal_acc = {octal_acc[2:0], b[2:0]};
          dec_mode  = DEC_OCTAL2;
        end else begin
          // emit the digits so far, then handle the ending byte again
          dec_mode = DEC_BODY;
          store_char({2'b00, octal_acc});
          body_byte(b);
        end
      end
      DEC_OCTAL2: begin
        dec_mode = DEC_BODY;
        if (is_octal(b)) begin
          store_char({octal_acc[4:0], b[2:0]});
        end else begin
          store_char({2'b00, octal_acc});
          body_byte(b);
        end
      end
      default: dec_mode = DEC_IDLE;
    endcase
  endtask

  always @(posedge clk) begin
    str_unesc_pkg::result_t want;
    if (rst) begin
      dec_mode       = DEC_IDLE;
      octal_acc      = '0;
      char_count     = '0;
      err_kind       = str_unesc_pkg::STATUS_OK;
      capacity       = str_unesc_pkg::CAP_RESET;
      mismatch_count = 0;
      due_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          $error("unexpected result word: char_out %0h char_valid %0b last %0b status %0d",
                 char_out, char_valid, last, status);
          mismatch_count++;
        end else begin
          want = due_words.pop_front();
          if (char_out !== want.char_out) begin
            $error("char_out expected %0h got %0h", want.char_out, char_out);
            mismatch_count++;
          end
          if (char_valid !== want.char_valid) begin
            $error("char_valid expected %0b got %0b", want.char_valid, char_valid);
            mismatch_count++;
          end
          if (last !== want.last) begin
            $error("last expected %0b got %0b", want.last, last);
            mismatch_count++;
          end
          if (status !== want.status) begin
            $error("status expected %0d got %0d", want.status, status);
            mismatch_count++;
          end
        end
      end
      if (cfg_wr_en) capacity = cfg_wr_data;
      if (in_valid && !in_stall) decode_byte(byte_in);
    end
  end

endmodule

// ===== tb/string_literal_unescape_core_test.sv =====
`timescale 1ns / 1ps
// Top of the string literal unescape testbench: clock, reset, byte stimulus,
// output stalls and the verdict. Depends on str_unesc_pkg, the core and its checker.

module string_literal_unescape_core_test;

  localparam int          RANDOM_BYTES = 850;
  localparam int          LONG_HOLD    = 64;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_wr_en = 1'b0;
  logic [str_unesc_pkg::CAP_WIDTH-1:0] cfg_wr_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [7:0]                          byte_in = 8'h00;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [7:0]                          char_out;
  logic                                char_valid;
  logic                                last;
  logic [1:0]                          status;

  int unsigned mismatch_count;
  int unsigned words_due;
  logic        decoder_idle;

  logic        quiet = 1'b0;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          burst_left = 0;
  int          bytes_sent = 0;
  int unsigned cycle_count = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  string_literal_unescape_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_out   (char_out),
    .char_valid (char_valid),
    .last       (last),
    .status     (status)
  );

  string_literal_unescape_checker decode_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .byte_in       (byte_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .char_out      (char_out),
    .char_valid    (char_valid),
    .last          (last),
    .status        (status),
    .mismatch_count(mismatch_count),
    .words_due     (words_due),
    .decoder_idle  (decoder_idle)
  );

  // Receiver: random stall bursts, plus a long hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Close any open string, then wait until every result word has come out.
  task automatic settle;
    while (!decoder_idle) send_byte(str_unesc_pkg::CH_QUOTE);
    in_valid <= 1'b0;
    @(negedge clk);
    while (words_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [str_unesc_pkg::CAP_WIDTH-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == str_unesc_pkg::CH_QUOTE || b == str_unesc_pkg::CH_BACKSLASH ||
        b == str_unesc_pkg::CH_NEWLINE) b = b ^ 8'h01;
    return b;
  endfunction

  task automatic send_random_string;
    logic [7:0] letters[6];
    logic [7:0] specials[3];
    int         parts;
    int         kind;
    int         digits;
    letters  = '{str_unesc_pkg::CH_LOWER_R, str_unesc_pkg::CH_LOWER_N,
                 str_unesc_pkg::CH_LOWER_B, str_unesc_pkg::CH_LOWER_T,
                 str_unesc_pkg::CH_LOWER_F, str_unesc_pkg::CH_LOWER_V};
    specials = '{str_unesc_pkg::CH_QUOTE, str_unesc_pkg::CH_BACKSLASH,
                 str_unesc_pkg::CH_NEWLINE};
    parts = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 10);
    send_byte(str_unesc_pkg::CH_QUOTE);
    repeat (parts) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        send_byte(plain_byte());
      end else if (kind < 65) begin
        send_byte(str_unesc_pkg::CH_BACKSLASH);
        send_byte(letters[$urandom_range(0, 5)]);
      end else if (kind < 75) begin
        send_byte(str_unesc_pkg::CH_BACKSLASH);
        send_byte(8'($urandom_range(0, 255)));
      end else if (kind < 92) begin
        digits = $urandom_range(1, 3);
        send_byte(str_unesc_pkg::CH_BACKSLASH);
        repeat (digits) send_byte(8'(str_unesc_pkg::CH_DIGIT_0 + $urandom_range(0, 7)));
      end else if (kind < 98) begin
        send_byte(str_unesc_pkg::CH_BACKSLASH);
        send_byte(specials[$urandom_range(0, 2)]);
      end else begin
        send_byte(str_unesc_pkg::CH_NEWLINE);
      end
    end
    // mostly close cleanly; sometimes hit end of file first
    if ($urandom_range(0, 19) == 0) begin
      send_byte(str_unesc_pkg::CH_NEWLINE);
      repeat ($urandom_range(0, 3)) send_byte(plain_byte());
    end
    send_byte(str_unesc_pkg::CH_QUOTE);
  endtask

  initial begin
    int rand_start;
    int phase;
    int phase_start;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Bytes outside a string, octal escapes with wrap and early ends,
    // raw newline, escaped quote and a letter escape.
    send_text("A");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("\"\\777\\4q\\12\"");
    send_text("\"a\nb\"");
    send_text("\"\\\"\\v\"");

    write_capacity(str_unesc_pkg::CAP_WIDTH'(1));
    send_text("\"ab\"");

    // Fill a short capacity and overflow it by one.
    write_capacity(str_unesc_pkg::CAP_WIDTH'(32));
    send_byte(str_unesc_pkg::CH_QUOTE);
    repeat (33) send_byte(plain_byte());
    send_byte(str_unesc_pkg::CH_QUOTE);

    rand_start = bytes_sent;
    phase = 0;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      case (phase)
        0: write_capacity(str_unesc_pkg::CAP_WIDTH'(1));
        1: write_capacity(str_unesc_pkg::CAP_WIDTH'(2));
        2: write_capacity(str_unesc_pkg::CAP_WIDTH'(255));
        default: begin
          if ($urandom_range(0, 3) == 0)
            write_capacity(str_unesc_pkg::CAP_WIDTH'($urandom_range(13, 4095)));
          else
            write_capacity(str_unesc_pkg::CAP_WIDTH'($urandom_range(1, 12)));
        end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 80) begin
        if (bytes_sent - rand_start > RANDOM_BYTES - 150) quiet = 1'b1;
        if (phase == 1 && bytes_sent - phase_start > 20 && hold_requests == 0)
          hold_requests++;
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
          while (!decoder_idle) send_byte(str_unesc_pkg::CH_QUOTE);
        end else begin
          send_random_string();
        end
      end
      phase++;
    end

    settle();
    if (mismatch_count == 0 && words_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
